@@ rtl/core/bmf_pkg.sv @@
package bmf_pkg;

  localparam int PIX_W    = 8;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 13;
  localparam int RADIUS_W = 4;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;

  localparam logic [CFG_AW-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_PASS_WAIT,
    ST_ACC,
    ST_DRAIN,
    ST_DIV,
    ST_FIN
  } bmf_state_t;

endpackage

@@ rtl/core/box_mean_filter.sv @@
// Square box mean filter over one 8-bit channel, one frame in raster order.
// Input beats: in_tdata carries the pixel, in_tuser selects pixel (0) or
// flush (1). After a frame's pixels, one flush beat per remaining output
// drains the delayed pixels; a pixel beat after a complete frame, or a flush
// beat before it, is dropped with no output.
// Outputs follow the input by r rows plus r pixels. Pixels within r of an
// edge pass through unchanged, others become the window mean, truncated.
// out_tlast marks the last pixel of the frame.
// Each beat is handled one at a time. A pass-through output reads the
// line store once; an interior output reads it once per window pixel and
// then runs a 17-step serial divider.
// The block takes the next input beat while a finished output waits; when
// the receiver stalls, at most one further output is computed and held.
// Reset is synchronous: r = 1, 1024 x 1024 frame, positions at zero, and
// in_tready held low while the derived geometry settles. A config write
// restarts the frame and holds in_tready low in the same way.
module box_mean_filter
  import bmf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 9,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] pixel_value
  input  logic              in_tuser,   // [0] opcode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] pixel_out
  output logic              out_tlast
);

  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int GW    = $clog2(RING);
  localparam int POSW  = XW + YW;
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(RING * RING * 255 + 1);
  localparam int DW    = $clog2(RING * RING + 1);

  logic [RADIUS_W-1:0] cfg_r_r;
  logic [WIDTH_W-1:0]  cfg_w_r;
  logic [HEIGHT_W-1:0] cfg_h_r;
  logic                dirty_r;

  logic [RW-1:0]   r_r;
  logic [XW-1:0]   w_r;
  logic [YW-1:0]   h_r;
  logic [POSW-1:0] delay_r, total_r;
  logic [DW-1:0]   area_r;
  logic [RW-1:0]   r_c;
  logic [XW-1:0]   w_c;
  logic [YW-1:0]   h_c;

  bmf_state_t state_r, state_nxt;

  logic [POSW-1:0] in_pos_r;
  logic [XW-1:0]   in_x_r;
  logic [GW-1:0]   in_ring_r;
  logic [XW-1:0]   out_x_r;
  logic [YW-1:0]   out_y_r;
  logic [GW-1:0]   out_ring_r;
  logic [GW-1:0]   wr_ring_r;
  logic [RW:0]     wr_cnt_r;
  logic [XW-1:0]   wc_r;
  logic [RW:0]     wc_cnt_r;
  logic            rd_vld_r;
  logic [SW-1:0]   sum_r;
  logic [PIX_W-1:0] res_r;
  logic            out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic            out_last_r;

  logic            accept, is_pix, is_flush, pix_ok, emit, interior, last_win, frame_last;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [PIX_W-1:0] rd_data;
  logic            div_start, div_done;
  logic [SW-1:0]   div_q;
  logic [SW-1:0]   div_num;
  logic [GW-1:0]   win_ring0;

  // Clamp the registers to their usable ranges.
  always_comb begin
    if (cfg_r_r == '0) r_c = RW'(1);
    else if (32'(cfg_r_r) > MAX_RADIUS) r_c = RW'(MAX_RADIUS);
    else r_c = RW'(cfg_r_r);
    if (cfg_w_r == '0) w_c = XW'(1);
    else if (32'(cfg_w_r) > MAX_WIDTH) w_c = XW'(MAX_WIDTH);
    else w_c = XW'(cfg_w_r);
    if (cfg_h_r == '0) h_c = YW'(1);
    else if (32'(cfg_h_r) > MAX_HEIGHT) h_c = YW'(MAX_HEIGHT);
    else h_c = YW'(cfg_h_r);
  end

  assign in_tready = (state_r == ST_IDLE) && !dirty_r;
  assign accept    = in_tvalid && in_tready;
  assign is_pix    = accept && (in_tuser == OP_PIXEL);
  assign is_flush  = accept && (in_tuser == OP_FLUSH);
  assign pix_ok    = is_pix && (in_pos_r != total_r);
  assign emit      = (pix_ok && (in_pos_r >= delay_r)) || (is_flush && (in_pos_r == total_r));

  assign interior = !((YW'(out_y_r) < YW'(r_r)) ||
                      ((YW + 1)'(out_y_r) + (YW + 1)'(r_r) >= (YW + 1)'(h_r)) ||
                      (XW'(out_x_r) < XW'(r_r)) ||
                      ((XW + 1)'(out_x_r) + (XW + 1)'(r_r) >= (XW + 1)'(w_r)));

  assign win_ring0 = (out_ring_r >= GW'(r_r)) ? (out_ring_r - GW'(r_r))
                                              : GW'(out_ring_r + GW'(RING) - GW'(r_r));
  assign last_win   = (wr_cnt_r == {r_r, 1'b0}) && (wc_cnt_r == {r_r, 1'b0});
  assign frame_last = (out_x_r == w_r - 1'b1) && (out_y_r == h_r - 1'b1);

  assign wr_addr = AW'(AW'(in_ring_r) * AW'(MAX_WIDTH)) + AW'(in_x_r);
  assign rd_addr = (state_r == ST_ACC) ? AW'(AW'(wr_ring_r) * AW'(MAX_WIDTH)) + AW'(wc_r)
                                       : AW'(AW'(out_ring_r) * AW'(MAX_WIDTH)) + AW'(out_x_r);

  assign div_start = (state_r == ST_DRAIN);
  // The last window pixel is still on the read port when the divider starts.
  assign div_num   = sum_r + SW'(rd_data);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (emit) state_nxt = interior ? ST_ACC : ST_PASS;
      ST_PASS:      state_nxt = ST_PASS_WAIT;
      ST_PASS_WAIT: state_nxt = ST_FIN;
      ST_ACC:       if (last_win) state_nxt = ST_DRAIN;
      ST_DRAIN:     state_nxt = ST_DIV;
      ST_DIV:       if (div_done) state_nxt = ST_FIN;
      ST_FIN:       if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r_r     <= RADIUS_W'(1);
      cfg_w_r     <= WIDTH_W'(1024);
      cfg_h_r     <= HEIGHT_W'(1024);
      dirty_r     <= 1'b1;
      in_pos_r    <= '0;
      in_x_r      <= '0;
      in_ring_r   <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_ring_r  <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_RADIUS: cfg_r_r <= cfg_wdata[RADIUS_W-1:0];
          CFG_WIDTH:  cfg_w_r <= cfg_wdata[WIDTH_W-1:0];
          CFG_HEIGHT: cfg_h_r <= cfg_wdata[HEIGHT_W-1:0];
          default: ;
        endcase
        if (cfg_addr == CFG_RADIUS || cfg_addr == CFG_WIDTH || cfg_addr == CFG_HEIGHT) begin
          dirty_r    <= 1'b1;
          in_pos_r   <= '0;
          in_x_r     <= '0;
          in_ring_r  <= '0;
          out_x_r    <= '0;
          out_y_r    <= '0;
          out_ring_r <= '0;
        end
      end else begin
        dirty_r <= 1'b0;
      end
      if (pix_ok) begin
        in_pos_r <= in_pos_r + 1'b1;
        if (in_x_r == w_r - 1'b1) begin
          in_x_r    <= '0;
          in_ring_r <= (in_ring_r == GW'(RING - 1)) ? '0 : in_ring_r + 1'b1;
        end else begin
          in_x_r <= in_x_r + 1'b1;
        end
      end
      rd_vld_r <= (state_r == ST_ACC);
      if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
        if (frame_last) begin
          in_pos_r   <= '0;
          in_x_r     <= '0;
          in_ring_r  <= '0;
          out_x_r    <= '0;
          out_y_r    <= '0;
          out_ring_r <= '0;
        end else if (out_x_r == w_r - 1'b1) begin
          out_x_r    <= '0;
          out_y_r    <= out_y_r + 1'b1;
          out_ring_r <= (out_ring_r == GW'(RING - 1)) ? '0 : out_ring_r + 1'b1;
        end else begin
          out_x_r <= out_x_r + 1'b1;
        end
      end
    end
    // Derived frame geometry, registered from the clamped values and settled in the cycle after any register write.
    r_r     <= r_c;
    w_r     <= w_c;
    h_r     <= h_c;
    delay_r <= POSW'(POSW'(r_c) * POSW'(w_c)) + POSW'(r_c);
    total_r <= POSW'(POSW'(w_c) * POSW'(h_c));
    area_r  <= DW'(DW'({r_c, 1'b1}) * DW'({r_c, 1'b1}));
    // Window walk: columns inner, rows outer.
    if (state_r == ST_IDLE && emit) begin
      wr_ring_r <= win_ring0;
      wr_cnt_r  <= '0;
      wc_r      <= out_x_r - XW'(r_r);
      wc_cnt_r  <= '0;
      sum_r     <= '0;
    end else if (state_r == ST_ACC) begin
      if (wc_cnt_r == {r_r, 1'b0}) begin
        wc_cnt_r  <= '0;
        wc_r      <= out_x_r - XW'(r_r);
        wr_cnt_r  <= wr_cnt_r + 1'b1;
        wr_ring_r <= (wr_ring_r == GW'(RING - 1)) ? '0 : wr_ring_r + 1'b1;
      end else begin
        wc_cnt_r <= wc_cnt_r + 1'b1;
        wc_r     <= wc_r + 1'b1;
      end
    end
    if (rd_vld_r) sum_r <= sum_r + SW'(rd_data);
    if (state_r == ST_PASS_WAIT) res_r <= rd_data;
    if (state_r == ST_DIV && div_done) res_r <= div_q[PIX_W-1:0];
    if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
      out_data_r <= res_r;
      out_last_r <= frame_last;
    end
  end

  bmf_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (pix_ok),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmf_div #(.NW(SW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (area_r),
    .done  (div_done),
    .quot  (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/core/bmf_store.sv @@
module bmf_store
  import bmf_pkg::*;
#(
  parameter int DEPTH = 19456,
  parameter int AW    = 15
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [PIX_W-1:0] rd_data
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/bmf_div.sv @@
module bmf_div #(
  parameter int NW = 17,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial    = {rem_r[DW-1:0], quo_r[NW-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ bench/tb_box_mean_filter.sv @@
`timescale 1ns / 100ps

module tb_box_mean_filter;
  import bmf_pkg::*;

  localparam int RING_ROWS  = 19;
  localparam int RING_COLS  = 1024;
  localparam int SETTLE_CYC = 420;   // longer than one interior output
  localparam int STALL_LIM  = 6000;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } mean_pixel_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] pixel_value
  logic                in_tuser;   // [0] opcode
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [7:0] pixel_out
  logic                out_tlast;

  box_mean_filter i_dut (.*);

  // Shadow of the filter state.
  logic [7:0]          ring_pix [RING_ROWS*RING_COLS];
  logic [RADIUS_W-1:0] radius_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int unsigned         in_pos, out_pos;
  mean_pixel_t         pending_pix[$];

  int  send_gap_pct, recv_stall_pct;
  int  error_count;
  int  quiet_cycles;
  int  beats_sent;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned cur_r();
    return clamp(radius_reg, 1, 9);
  endfunction
  function automatic int unsigned cur_w();
    return clamp(width_reg, 1, 1024);
  endfunction
  function automatic int unsigned cur_h();
    return clamp(height_reg, 1, 4096);
  endfunction

  function automatic int unsigned ring_idx(int unsigned row, int unsigned col);
    return (row % RING_ROWS) * RING_COLS + (col % RING_COLS);
  endfunction

  function automatic logic [7:0] mean_at(int unsigned p);
    int unsigned w, h, r, x, y, side, acc;
    w = cur_w();
    h = cur_h();
    r = cur_r();
    y = p / w;
    x = p % w;
    side = 2 * r + 1;
    acc = 0;
    if (y < r || y + r >= h || x < r || x + r >= w) return ring_pix[ring_idx(y, x)];
    for (int unsigned c = x - r; c <= x + r; c++)
      for (int unsigned rr = y - r; rr <= y + r; rr++)
        acc += ring_pix[ring_idx(rr, c)];
    return 8'(acc / (side * side));
  endfunction

  function automatic void emit_pixel();
    mean_pixel_t res;
    int unsigned total;
    total = cur_w() * cur_h();
    res.pixel = mean_at(out_pos);
    res.last  = (out_pos + 1 == total);
    pending_pix.push_back(res);
    if (res.last) begin
      in_pos  = 0;
      out_pos = 0;
    end else begin
      out_pos++;
    end
  endfunction

  function automatic void predict_beat(logic op, logic [7:0] value);
    int unsigned w, total, delay;
    w = cur_w();
    total = w * cur_h();
    delay = cur_r() * w + cur_r();
    if (op == OP_PIXEL) begin
      if (in_pos >= total) return;
      ring_pix[ring_idx(in_pos / w, in_pos % w)] = value;
      in_pos++;
      if (in_pos - 1 >= delay) emit_pixel();
    end else if (in_pos == total && out_pos < total) begin
      emit_pixel();
    end
  endfunction

  task automatic send_beat(logic op, logic [7:0] value);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    // The ready sampled at the edge itself decides the accept.
    @(posedge clk iff in_tready);
    predict_beat(op, value);
    beats_sent++;
  endtask

  // The block may still be busy on a beat that produced nothing.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] idx, int unsigned value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RADIUS: radius_reg = RADIUS_W'(value);
      CFG_WIDTH:  width_reg  = WIDTH_W'(value);
      CFG_HEIGHT: height_reg = HEIGHT_W'(value);
      default: ;
    endcase
    in_pos  = 0;
    out_pos = 0;
    @(posedge clk);
  endtask

  task automatic send_frame(bit noisy);
    int unsigned total, drain;
    logic [7:0] v;
    total = cur_w() * cur_h();
    drain = cur_r() * cur_w() + cur_r();
    if (drain > total) drain = total;
    for (int unsigned i = 0; i < total; i++) begin
      case ($urandom_range(9))
        0: v = 8'h00;
        1: v = 8'hff;
        default: v = 8'($urandom);
      endcase
      if (noisy && $urandom_range(19) == 0) send_beat(OP_FLUSH, 8'($urandom));
      send_beat(OP_PIXEL, v);
    end
    if (noisy) send_beat(OP_PIXEL, 8'($urandom));
    for (int unsigned i = 0; i < drain; i++) send_beat(OP_FLUSH, 8'($urandom));
    if (noisy) send_beat(OP_FLUSH, 8'($urandom));
  endtask

  task automatic test_small_frame_edges();
    cfg_write(CFG_RADIUS, 0);
    cfg_write(CFG_WIDTH, 3);
    cfg_write(CFG_HEIGHT, 3);
    send_beat(OP_FLUSH, 8'hff);
    for (int i = 0; i < 9; i++) send_beat(OP_PIXEL, (i % 2) ? 8'hff : 8'h00);
    send_beat(OP_PIXEL, 8'h5a);
    repeat (4) send_beat(OP_FLUSH, 8'h00);
    send_beat(OP_FLUSH, 8'ha5);
  endtask

  task automatic test_register_extremes();
    cfg_write(CFG_RADIUS, 15);
    cfg_write(CFG_WIDTH, 2047);
    cfg_write(CFG_HEIGHT, 8191);
    send_beat(OP_PIXEL, 8'h81);
    send_beat(OP_PIXEL, 8'h7e);
    cfg_write(CFG_WIDTH, 0);
    cfg_write(CFG_HEIGHT, 0);
    send_beat(OP_PIXEL, 8'hc3);
    send_beat(OP_FLUSH, 8'h3c);
  endtask

  task automatic test_widest_window();
    cfg_write(CFG_RADIUS, 9);
    cfg_write(CFG_WIDTH, 19);
    cfg_write(CFG_HEIGHT, 19);
    send_frame(1'b0);
  endtask

  task automatic test_random_frames(int gap, int stall, int quota);
    int unsigned start;
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    start = beats_sent;
    while (beats_sent - start < quota) begin
      if ($urandom_range(3) == 0) cfg_write(CFG_RADIUS, $urandom_range(0, 15));
      else cfg_write(CFG_RADIUS, $urandom_range(1, 2));
      cfg_write(CFG_WIDTH, $urandom_range(1, 16));
      cfg_write(CFG_HEIGHT, $urandom_range(1, 12));
      if ($urandom_range(7) == 0) begin
        // Abandon the frame partway through.
        repeat ($urandom_range(1, 10)) send_beat(OP_PIXEL, 8'($urandom));
      end else begin
        send_frame($urandom_range(3) == 0);
      end
      if ($urandom_range(4) == 0) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pix.size() != 0) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    mean_pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pix.size() == 0) begin
        $error("unexpected output beat: pixel_out %0d frame_end %0d", out_tdata, out_tlast);
        error_count++;
      end else begin
        want = pending_pix.pop_front();
        if (out_tdata !== want.pixel) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("frame_end: expected %0d, got %0d", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIM) begin
      $display("tb_box_mean_filter: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = CFG_RADIUS;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_PIXEL;
    out_tready     = 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    quiet_cycles   = 0;
    beats_sent     = 0;
    radius_reg     = 1;
    width_reg      = 1024;
    height_reg     = 1024;
    in_pos         = 0;
    out_pos        = 0;
    foreach (ring_pix[i]) ring_pix[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct   = 9;
    recv_stall_pct = 48;
    test_small_frame_edges();
    test_register_extremes();
    test_widest_window();
    test_random_frames(9, 48, 70);
    test_random_frames(48, 9, 70);
    test_random_frames(0, 0, 60);

    wait_idle();
    if (error_count == 0) begin
      $display("tb_box_mean_filter: done, clean");
    end else begin
      $display("tb_box_mean_filter: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bmf_pkg.sv
rtl/core/bmf_store.sv
rtl/core/bmf_div.sv
rtl/core/box_mean_filter.sv
bench/tb_box_mean_filter.sv
